// ----- rtl/core/stl_pkg.sv -----
// ----------------------------------------------------------------------------
// stl_pkg
// shared types, character codes and byte classing for the token lexer
// ----------------------------------------------------------------------------
package stl_pkg;

   localparam int POS_BITS_DEF = 16;
   localparam int MAX_NEST_DEF = 15;

   // character codes
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_TILDE = 8'h7e;
   localparam logic [7:0] CH_QUES  = 8'h3f;
   localparam logic [7:0] CH_UNDER = 8'h5f;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_NL    = 8'h0a;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LE    = 8'h65;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_LZ    = 8'h7a;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UE    = 8'h45;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_UZ    = 8'h5a;
   localparam logic [7:0] CH_LSQ   = 8'h5b;
   localparam logic [7:0] CH_RSQ   = 8'h5d;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_LBR   = 8'h7b;
   localparam logic [7:0] CH_RBR   = 8'h7d;

   typedef enum logic [3:0] {
      CLS_NUM   = 4'd0,
      CLS_ALPHA = 4'd1,
      CLS_VAR   = 4'd2,
      CLS_UND   = 4'd3,
      CLS_BRK   = 4'd4,
      CLS_SYM   = 4'd5,
      CLS_FLT   = 4'd6,
      CLS_NONE  = 4'd7,
      CLS_DOT   = 4'd8
   } class_type;

   typedef enum logic [5:0] {
      MODE_IDLE  = 6'b000001,
      MODE_CRUN  = 6'b000010,
      MODE_SKIP1 = 6'b000100,
      MODE_SCAN  = 6'b001000,
      MODE_LINE  = 6'b010000,
      MODE_TOKEN = 6'b100000
   } mode_type;

   typedef enum logic [1:0] {
      JUDGE_GO   = 2'd0,
      JUDGE_STOP = 2'd1,
      JUDGE_HOLD = 2'd2
   } judge_type;

   typedef struct packed {
      logic [15:0] tok_start;
      logic [15:0] tok_len;
      logic [2:0]  tok_kind;
      logic        text_end;
      logic        last_of_run;
   } rec_type;

   typedef struct packed {
      rec_type [2:0] rec;
      logic [1:0]    cnt;
   } rec_list_type;

   function automatic class_type byte_class(input logic [7:0] b);
      if (b < CH_BANG || b > CH_TILDE) return CLS_NONE;
      if (b >= CH_ZERO && b <= CH_NINE) return CLS_NUM;
      if ((b >= CH_LA && b <= CH_LZ) || (b >= CH_UA && b <= CH_UZ)) return CLS_ALPHA;
      if (b == CH_QUES) return CLS_VAR;
      if (b == CH_DOT) return CLS_DOT;
      if (b == CH_UNDER) return CLS_UND;
      if (b == CH_LSQ || b == CH_RSQ || b == CH_LPAR || b == CH_RPAR ||
          b == CH_LBR || b == CH_RBR) return CLS_BRK;
      return CLS_SYM;
   endfunction

   // append one record, dropped once three are held
   function automatic rec_list_type push_rec(input rec_list_type l,
                                             input logic [15:0] start,
                                             input logic [15:0] len,
                                             input class_type cls);
      rec_list_type r;
      r = l;
      if (l.cnt != 2'd3) begin
         r.rec[l.cnt].tok_start   = start;
         r.rec[l.cnt].tok_len     = len;
         r.rec[l.cnt].tok_kind    = (cls == CLS_DOT) ? 3'(CLS_SYM) : cls[2:0];
         r.rec[l.cnt].text_end    = 1'b0;
         r.rec[l.cnt].last_of_run = 1'b0;
         r.cnt = l.cnt + 2'd1;
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/stl_if.sv -----
// ----------------------------------------------------------------------------
// stl channel interfaces
// byte input channel and token record output channel
// ----------------------------------------------------------------------------
interface stl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;
   modport source (output valid, ch, last, input ready);
   modport sink (input valid, ch, last, output ready);
endinterface

interface stl_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] tok_start;
   logic [15:0] tok_len;
   logic [2:0]  tok_kind;
   logic        text_end;
   logic        last_of_run;
   modport source (output valid, tok_start, tok_len, tok_kind, text_end, last_of_run,
                   input ready);
   modport sink (input valid, tok_start, tok_len, tok_kind, text_end, last_of_run,
                 output ready);
endinterface

// ----- rtl/core/source_token_lexer.sv -----
// ----------------------------------------------------------------------------
// source_token_lexer
// splits a byte stream into token records (start, length, kind)
// ----------------------------------------------------------------------------
//  channel   dir  payload                                          item
//  req_chan  in   ch, last                                         one text byte
//  rsp_chan  out  tok_start, tok_len, tok_kind, text_end, last_of_run  one token
//
//  one byte a cycle while req_chan.ready allows; lexer state updates at the byte handshake
//  a byte gives 0 to 3 records, held in a 3-entry result buffer drained one a cycle while rsp_chan is ready
//  next byte is taken when the buffer is empty or its final record leaves this cycle
//  so a byte giving k records holds the output until all k of them have left
//  synchronous reset clears lexer state and empties the buffer
//  end of text (zero byte or last) returns the lexer to its reset state
// ----------------------------------------------------------------------------
module source_token_lexer #(
   parameter int POS_BITS = stl_pkg::POS_BITS_DEF,
   parameter int MAX_NEST = stl_pkg::MAX_NEST_DEF
) (
   input  logic clock,
   input  logic reset,
   stl_req_if.sink   req_chan,
   stl_rsp_if.source rsp_chan
);
   import stl_pkg::*;

   localparam int NEST_BITS = $clog2(MAX_NEST + 1);

   typedef struct packed {
      logic [POS_BITS-1:0]  pos;      // offset of the next byte
      logic [POS_BITS-1:0]  origin;   // first byte of open token or comment
      mode_type             mode;
      class_type            cls;      // running token class
      logic [7:0]           p1;       // previous byte
      logic [7:0]           p2;       // byte before that
      logic                 hex;
      logic [1:0]           count;    // token bytes seen after the first, saturating
      logic [NEST_BITS-1:0] nest;
      class_type            cprev;    // comment: class of previous byte
      logic [1:0]           urun;     // underscore run, saturating
      logic                 held;     // dot after word awaiting lookahead
   } lex_state_type;

   localparam lex_state_type STATE_RESET = '{
      pos: '0, origin: '0, mode: MODE_IDLE, cls: CLS_NONE, p1: '0, p2: '0,
      hex: 1'b0, count: '0, nest: '0, cprev: CLS_NONE, urun: '0, held: 1'b0};

   lex_state_type state_ff, state_in;
   rec_type [2:0] rec_ff, rec_in;
   logic [1:0]    cnt_ff, cnt_in;
   rec_list_type  list_new;
   logic          req_fire, rsp_fire, fin;

   function automatic logic [15:0] to16(input logic [POS_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[15:0];
   endfunction

   // emit the open token, splitting off a trailing colon
   function automatic void close_token(input logic [POS_BITS-1:0] endpos,
                                       input logic [7:0] lastb,
                                       inout lex_state_type s,
                                       inout rec_list_type l);
      logic [POS_BITS-1:0] span;
      span = endpos - s.origin;
      if (span > POS_BITS'(1) && lastb == CH_COLON) begin
         l = push_rec(l, to16(s.origin), to16(span - POS_BITS'(1)), s.cls);
         l = push_rec(l, to16(s.origin + span - POS_BITS'(1)), 16'd1, CLS_SYM);
      end else begin
         l = push_rec(l, to16(s.origin), to16(span), s.cls);
      end
   endfunction

   function automatic void begin_idle(input logic [7:0] b,
                                      inout lex_state_type s,
                                      inout rec_list_type l);
      class_type k;
      k = byte_class(b);
      s.mode = MODE_IDLE;
      if (k == CLS_UND) begin
         s.mode   = MODE_CRUN;
         s.nest   = '0;
         s.cprev  = CLS_NONE;
         s.urun   = 2'd1;
         s.origin = s.pos;
      end else if (k == CLS_BRK) begin
         l = push_rec(l, to16(s.pos), 16'd1, CLS_BRK);
      end else if (k != CLS_NONE) begin
         s.mode   = MODE_TOKEN;
         s.origin = s.pos;
         s.cls    = k;
         s.count  = '0;
         s.hex    = 1'b0;
         s.held   = 1'b0;
      end
   endfunction

   function automatic void comment_run(input logic [7:0] b,
                                       inout lex_state_type s,
                                       inout rec_list_type l);
      class_type k;
      logic      done;
      k    = byte_class(b);
      done = 1'b0;
      if (k == CLS_UND) begin
         if (s.urun != 2'd2) s.urun = s.urun + 2'd1;
         done = 1'b1;
      end else if (s.cprev == CLS_NONE) begin
         if (k != CLS_NONE) begin
            if (s.nest < NEST_BITS'(MAX_NEST)) s.nest = s.nest + NEST_BITS'(1);
         end else if (s.nest == '0) begin
            done = 1'b1;
            if (s.urun > 2'd1) begin
               s.mode = (b == CH_NL) ? MODE_IDLE : MODE_LINE;
            end else begin
               l = push_rec(l, to16(s.origin), 16'd1, CLS_UND);
               s.mode = MODE_IDLE;
            end
         end
      end else if (k == CLS_NONE) begin
         if (s.nest != '0) s.nest = s.nest - NEST_BITS'(1);
         if (s.nest == '0) begin
            s.mode = MODE_IDLE;
            done = 1'b1;
         end
      end
      if (!done) begin
         s.cprev = k;
         s.mode  = MODE_SKIP1;
      end
   endfunction

   function automatic judge_type token_judge(input logic [7:0] b,
                                             inout lex_state_type s);
      class_type nk, ck;
      nk = byte_class(b);
      ck = s.cls;
      if (s.count != 2'd3) s.count = s.count + 2'd1;
      if (ck == nk || ck == CLS_NONE) begin
         s.cls = nk;
         return JUDGE_GO;
      end
      unique case (nk)
         CLS_NUM: begin
            if (ck == CLS_FLT) return JUDGE_GO;
            if (s.p1 == CH_MINUS) begin
               s.cls = CLS_NUM;
               return JUDGE_GO;
            end
            return (ck == CLS_ALPHA) ? JUDGE_GO : JUDGE_STOP;
         end
         CLS_UND: return (ck == CLS_ALPHA || ck == CLS_SYM) ? JUDGE_GO : JUDGE_STOP;
         CLS_DOT: return (ck == CLS_ALPHA || ck == CLS_NUM) ? JUDGE_HOLD : JUDGE_STOP;
         CLS_ALPHA: begin
            if (ck == CLS_NUM) begin
               // hex prefix 0x or -0x
               if (b == CH_X && (s.count == 2'd1 || s.count == 2'd2) && s.p1 == CH_ZERO &&
                   (s.count == 2'd1 || s.p2 == CH_MINUS)) begin
                  s.hex = 1'b1;
                  return JUDGE_GO;
               end
               if (s.hex && ((b >= CH_LA && b <= CH_LF) || (b >= CH_UA && b <= CH_UF)))
                  return JUDGE_GO;
            end
            if ((ck == CLS_NUM || ck == CLS_FLT) && (b == CH_LE || b == CH_UE)) begin
               s.cls = CLS_FLT;
               return JUDGE_GO;
            end
            if (ck == CLS_SYM && s.p1 != CH_COLON) begin
               s.cls = CLS_ALPHA;
               return JUDGE_GO;
            end
            return JUDGE_STOP;
         end
         default: return JUDGE_STOP;
      endcase
   endfunction

   // dot after a word not followed by a second dot
   function automatic void resolve_dot(inout lex_state_type s);
      s.cls  = (s.cls == CLS_ALPHA) ? CLS_NONE : CLS_FLT;
      s.held = 1'b0;
   endfunction

   function automatic void token_feed(input logic [7:0] b,
                                      inout lex_state_type s,
                                      inout rec_list_type l);
      judge_type r;
      if (s.held) begin
         if (b == CH_DOT) begin
            // double dot: close word, dots start a symbol
            s.held = 1'b0;
            close_token(s.pos - POS_BITS'(1), s.p2, s, l);
            s.origin = s.pos - POS_BITS'(1);
            s.cls    = CLS_DOT;
            s.count  = '0;
            s.hex    = 1'b0;
         end else begin
            resolve_dot(s);
         end
      end
      r = token_judge(b, s);
      if (r == JUDGE_HOLD) begin
         s.held = 1'b1;
      end else if (r == JUDGE_STOP) begin
         close_token(s.pos, s.p1, s, l);
         begin_idle(b, s, l);
      end
   endfunction

   // per-byte lexer step
   always_comb begin
      lex_state_type s;
      rec_list_type  l;
      logic [7:0]    b;
      b   = req_chan.ch;
      fin = (b == 8'd0) || req_chan.last;
      s   = state_ff;
      l   = '0;
      if (b != 8'd0) begin
         unique case (state_ff.mode)
            MODE_CRUN:  comment_run(b, s, l);
            MODE_SKIP1: s.mode = MODE_SCAN;
            MODE_SCAN: begin
               if (byte_class(b) == CLS_UND) begin
                  s.urun = 2'd1;
                  s.mode = MODE_CRUN;
               end else begin
                  s.cprev = byte_class(b);
               end
            end
            MODE_LINE:  if (b == CH_NL) s.mode = MODE_IDLE;
            MODE_TOKEN: token_feed(b, s, l);
            default:    begin_idle(b, s, l);   // idle and unused codes
         endcase
         s.p2  = s.p1;
         s.p1  = b;
         s.pos = s.pos + POS_BITS'(1);
      end
      if (fin) begin
         // end of text: close open token, drop open comment
         if (s.mode == MODE_TOKEN) begin
            if (s.held) resolve_dot(s);
            close_token(s.pos, s.p1, s, l);
         end
         if (l.cnt == 2'd0) l = push_rec(l, to16(s.pos), 16'd0, CLS_NONE);
      end
      if (l.cnt != 2'd0) begin
         l.rec[l.cnt - 2'd1].last_of_run = 1'b1;
         l.rec[l.cnt - 2'd1].text_end    = fin;
      end
      state_in = fin ? STATE_RESET : s;
      list_new = l;
   end

   // result buffer: shift out one record per handshake
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      rec_in = rec_ff;
      cnt_in = cnt_ff;
      if (req_fire) begin
         rec_in = list_new.rec;
         cnt_in = list_new.cnt;
      end else if (rsp_fire) begin
         rec_in[0] = rec_ff[1];
         rec_in[1] = rec_ff[2];
         cnt_in    = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
         cnt_ff   <= '0;
      end else begin
         if (req_fire) state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
      rec_ff <= rec_in;
   end

   assign rsp_chan.valid       = (cnt_ff != 2'd0);
   assign rsp_chan.tok_start   = rec_ff[0].tok_start;
   assign rsp_chan.tok_len     = rec_ff[0].tok_len;
   assign rsp_chan.tok_kind    = rec_ff[0].tok_kind;
   assign rsp_chan.text_end    = rec_ff[0].text_end;
   assign rsp_chan.last_of_run = rec_ff[0].last_of_run;

`ifndef NO_ASSERTIONS
   // the final buffered record of a byte carries the run marker
   a_last_rec: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) |-> rec_ff[0].last_of_run)
      else $error("single buffered record lacks last_of_run");

   // end of text returns the lexer to offset zero, between tokens
   a_fin_reset: assert property (@(posedge clock) disable iff (reset)
      (req_fire && fin) |=> (state_ff.pos == '0 && state_ff.mode == MODE_IDLE))
      else $error("lexer state not cleared after end of text");

   // end of text always yields at least one record
   a_fin_rec: assert property (@(posedge clock) disable iff (reset)
      (req_fire && fin) |=> (cnt_ff != 2'd0))
      else $error("end of text gave no record");

   // text_end only on the final record of a byte
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rec_ff[0].text_end) |-> rec_ff[0].last_of_run)
      else $error("text_end without last_of_run");
`endif

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// source_token_lexer testbench
// drives text bytes with random gaps, predicts token records per byte and
// checks every record in order against a queue of expected records
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import stl_pkg::*;

   localparam int POS_MASK = 16'hffff;
   localparam int CYCLE_LIMIT = 200000;

   typedef enum int {
      LX_IDLE, LX_CRUN, LX_SKIP1, LX_SCAN, LX_LINE, LX_TOKEN
   } lx_mode_e;

   // ---------------------------------------------------------------------
   // scoreboard: token lexer predictor plus queue of expected records
   // ---------------------------------------------------------------------
   class token_board;
      rec_type    pending[$];
      int         errors;
      int         pos, origin, rbytes, chars, nest, urun;
      bit         hexf, held;
      class_type  cls, cprev;
      lx_mode_e   mode;
      rec_type    step_recs[$];

      function new();
         errors = 0;
         clear_state();
      endfunction

      function void clear_state();
         pos = 0; origin = 0; rbytes = 0; chars = 0; nest = 0; urun = 0;
         hexf = 0; held = 0; cls = CLS_NONE; cprev = CLS_NONE; mode = LX_IDLE;
      endfunction

      function void emit(int from, int span, class_type k);
         rec_type r;
         if (step_recs.size() >= 3) return;
         r.tok_start = from[15:0];
         r.tok_len = span[15:0];
         r.tok_kind = (k == CLS_DOT) ? 3'(CLS_SYM) : k[2:0];
         r.text_end = 0;
         r.last_of_run = 0;
         step_recs.push_back(r);
      endfunction

      // close the open token, splitting a trailing colon off
      function void close_tok(int endpos, logic [7:0] lastb);
         int span;
         span = (endpos - origin) & POS_MASK;
         if (span > 1 && lastb == CH_COLON) begin
            emit(origin, span - 1, cls);
            emit((origin + span - 1) & POS_MASK, 1, CLS_SYM);
         end else begin
            emit(origin, span, cls);
         end
      endfunction

      function void start_idle(logic [7:0] b);
         class_type k;
         k = byte_class(b);
         mode = LX_IDLE;
         if (k == CLS_NONE) return;
         if (k == CLS_UND) begin
            mode = LX_CRUN; nest = 0; cprev = CLS_NONE; urun = 1; origin = pos;
         end else if (k == CLS_BRK) begin
            emit(pos, 1, CLS_BRK);
         end else begin
            mode = LX_TOKEN; origin = pos; cls = k; chars = 0; hexf = 0; held = 0;
         end
      endfunction

      function void comment_step(logic [7:0] b);
         class_type k;
         k = byte_class(b);
         if (k == CLS_UND) begin
            if (urun < 2) urun++;
            return;
         end
         if (cprev == CLS_NONE) begin
            if (k != CLS_NONE) begin
               if (nest < MAX_NEST_DEF) nest++;
            end else if (nest == 0) begin
               if (urun > 1) mode = (b == CH_NL) ? LX_IDLE : LX_LINE;
               else begin
                  emit(origin, 1, CLS_UND);
                  mode = LX_IDLE;
               end
               return;
            end
         end else if (k == CLS_NONE) begin
            if (nest > 0) nest--;
            if (nest == 0) begin
               mode = LX_IDLE;
               return;
            end
         end
         cprev = k;
         mode = LX_SKIP1;
      endfunction

      function judge_type judge(logic [7:0] b);
         logic [7:0] p1, p2;
         class_type nk, ck;
         p1 = rbytes[7:0];
         p2 = rbytes[15:8];
         nk = byte_class(b);
         ck = cls;
         if (chars < 3) chars++;
         if (ck == nk || ck == CLS_NONE) begin
            cls = nk;
            return JUDGE_GO;
         end
         case (nk)
            CLS_NUM: begin
               if (ck == CLS_FLT) return JUDGE_GO;
               if (p1 == CH_MINUS) begin
                  cls = CLS_NUM;
                  return JUDGE_GO;
               end
               return (ck == CLS_ALPHA) ? JUDGE_GO : JUDGE_STOP;
            end
            CLS_UND: return (ck == CLS_ALPHA || ck == CLS_SYM) ? JUDGE_GO : JUDGE_STOP;
            CLS_DOT: return (ck == CLS_ALPHA || ck == CLS_NUM) ? JUDGE_HOLD : JUDGE_STOP;
            CLS_ALPHA: begin
               if (ck == CLS_NUM) begin
                  if (b == CH_X && (chars == 1 || chars == 2) && p1 == CH_ZERO &&
                      (chars == 1 || p2 == CH_MINUS)) begin
                     hexf = 1;
                     return JUDGE_GO;
                  end
                  if (hexf && ((b >= CH_LA && b <= CH_LF) || (b >= CH_UA && b <= CH_UF)))
                     return JUDGE_GO;
               end
               if ((ck == CLS_NUM || ck == CLS_FLT) && (b == CH_LE || b == CH_UE)) begin
                  cls = CLS_FLT;
                  return JUDGE_GO;
               end
               if (ck == CLS_SYM && p1 != CH_COLON) begin
                  cls = CLS_ALPHA;
                  return JUDGE_GO;
               end
               return JUDGE_STOP;
            end
            default: return JUDGE_STOP;
         endcase
      endfunction

      // a held dot not followed by another dot joins the word
      function void join_dot();
         cls = (cls == CLS_ALPHA) ? CLS_NONE : CLS_FLT;
         held = 0;
      endfunction

      function void token_step(logic [7:0] b);
         judge_type r;
         if (held) begin
            if (b == CH_DOT) begin
               held = 0;
               close_tok((pos - 1) & POS_MASK, rbytes[15:8]);
               origin = (pos - 1) & POS_MASK;
               cls = CLS_DOT; chars = 0; hexf = 0;
            end else join_dot();
         end
         r = judge(b);
         if (r == JUDGE_HOLD) held = 1;
         else if (r == JUDGE_STOP) begin
            close_tok(pos, rbytes[7:0]);
            start_idle(b);
         end
      endfunction

      // predict the records one accepted byte causes
      function void note_byte(logic [7:0] b, logic lst);
         bit fin;
         fin = (b == 0) || lst;
         step_recs.delete();
         if (b != 0) begin
            case (mode)
               LX_CRUN:  comment_step(b);
               LX_SKIP1: mode = LX_SCAN;
               LX_SCAN: begin
                  if (byte_class(b) == CLS_UND) begin
                     urun = 1;
                     mode = LX_CRUN;
                  end else cprev = byte_class(b);
               end
               LX_LINE:  if (b == CH_NL) mode = LX_IDLE;
               LX_TOKEN: token_step(b);
               default:  start_idle(b);
            endcase
            rbytes = ((rbytes << 8) | b) & POS_MASK;
            pos = (pos + 1) & POS_MASK;
         end
         if (fin) begin
            if (mode == LX_TOKEN) begin
               if (held) join_dot();
               close_tok(pos, rbytes[7:0]);
            end
            if (step_recs.size() == 0) emit(pos, 0, CLS_NONE);
         end
         if (step_recs.size() > 0) begin
            step_recs[$].last_of_run = 1;
            if (fin) step_recs[$].text_end = 1;
         end
         foreach (step_recs[i]) pending.push_back(step_recs[i]);
         if (fin) clear_state();
      endfunction

      function void check_rec(rec_type got);
         rec_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected record %p", $realtime, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.tok_start !== want.tok_start)
            $display("%0t: tok_start exp %0d got %0d", $realtime, want.tok_start,
                     got.tok_start);
         if (got.tok_len !== want.tok_len)
            $display("%0t: tok_len exp %0d got %0d", $realtime, want.tok_len, got.tok_len);
         if (got.tok_kind !== want.tok_kind)
            $display("%0t: tok_kind exp %0d got %0d", $realtime, want.tok_kind,
                     got.tok_kind);
         if (got.text_end !== want.text_end)
            $display("%0t: text_end exp %0b got %0b", $realtime, want.text_end,
                     got.text_end);
         if (got.last_of_run !== want.last_of_run)
            $display("%0t: last_of_run exp %0b got %0b", $realtime, want.last_of_run,
                     got.last_of_run);
         if (got !== want) errors++;
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   int   cycles = 0;
   bit   hold_off = 0;   // long receiver stall requested by the stimulus
   bit   stim_done = 0;
   token_board board;

   stl_req_if req_chan();
   stl_rsp_if rsp_chan();

   source_token_lexer dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   initial begin
      req_chan.valid = 0;
      req_chan.ch = 0;
      req_chan.last = 0;
      rsp_chan.ready = 0;
   end

   // cycle counter and timeout guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // accepted items are sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         board.note_byte(req_chan.ch, req_chan.last);
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_rec({rsp_chan.tok_start, rsp_chan.tok_len, rsp_chan.tok_kind,
                          rsp_chan.text_end, rsp_chan.last_of_run});
   end

   // receiver: random stalls per item, plus a long hold-off on request
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_chan.ready <= 0;
            repeat (60) @(negedge clock);
            hold_off = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
         if (gap > 0) begin
            rsp_chan.ready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1;
         @(posedge clock);
         while (!(rsp_chan.valid && rsp_chan.ready)) @(posedge clock);
         @(negedge clock);
      end
   end

   // send one byte, with a random gap first, and wait for acceptance
   // valid stays high until the next byte or gap replaces it
   task automatic send_byte(input logic [7:0] b, input logic lst);
      int gap;
      gap = $urandom_range(0, 4);
      if (($urandom_range(0, 2)) == 0) gap = 0;
      if (gap > 0) begin
         req_chan.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1;
      req_chan.ch <= b;
      req_chan.last <= lst;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input bit end_last);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], end_last && (i == s.len() - 1));
      if (!end_last) send_byte(8'h00, 0);
   endtask

   // random token pieces, mostly well formed
   function automatic string rand_piece();
      string frag[$] = '{"abc", "x.y", "-0x1f", "0x", "3.5e2", "1e", "foo:", "?v",
                         "a_b", "+q", ":a", "(", "]", "__ line\n", "_ x _", "_a_b_ ",
                         "a..b", "7.", "-12", "a.b.c", "0xAF", "{", "___", "_",
                         "x1", "-", ".", "=>", " ", "\n"};
      string s;
      int c;
      c = $urandom_range(0, 9);
      if (c == 0) begin
         s = " ";
         s[0] = $urandom_range(1, 255);
         return s;
      end
      return frag[$urandom_range(0, frag.size() - 1)];
   endfunction

   initial begin
      string txt;
      int n;
      logic [7:0] b;
      board = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed texts covering every class and special case
      send_text("abc 123 -45 0x1F -0xab ", 0);
      send_text("1.5 2e3 a.b x..y q. ?v [ ] ( ) { } ", 1);
      send_text("foo: : __ line comment\nz _ _a b_ _x ", 0);
      send_text("+abc a_b 9e- ~", 1);
      send_byte(8'h7f, 0); send_byte(8'hff, 0); send_byte(8'h80, 0);
      send_byte(8'h01, 0); send_byte(8'h00, 0);
      send_byte(8'h00, 0);
      send_byte(8'h5f, 1);
      send_byte(8'h2e, 1);
      send_text("a.", 1);
      // a long comment of repeated word and underscore groups
      txt = "_";
      for (int i = 0; i < 16; i++) txt = {txt, "a _"};
      send_text({txt, " "}, 0);

      // long receiver hold-off while the sender keeps offering items
      hold_off = 1;
      send_text("a : b : c : d : e : f : g : h : ( ) [ ] x", 1);

      n = 0;
      while (n < 24) begin
         txt = "";
         repeat ($urandom_range(1, 8)) txt = {txt, rand_piece()};
         if ($urandom_range(0, 1)) send_text(txt, 1);
         else send_text(txt, 0);
         n += txt.len();
      end
      // random noise bytes
      repeat (12) begin
         b = $urandom_range(0, 255);
         send_byte(b, $urandom_range(0, 7) == 0);
      end
      send_byte(8'h00, 1);
      req_chan.valid <= 0;
      stim_done = 1;

      while (board.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
